// ===== src/vrp_pkg.sv =====
package vrp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned AngW   = FracW + 3;
  localparam int unsigned Stages = 16;
  localparam int unsigned GuardW = 8;
  // CORDIC datapath: coordinates with guard bits plus growth, angles in Q30.
  localparam int unsigned CordW  = 44;
  localparam int unsigned ZW     = 34;

  localparam logic [30:0]          GainInv   = 31'd1304065748;
  localparam logic signed [ZW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;

  typedef enum logic [2:0] {
    MODE_RECT  = 3'd0,
    MODE_POLAR = 3'd1,
    MODE_ADD   = 3'd2,
    MODE_SUB   = 3'd3,
    MODE_NEG   = 3'd4,
    MODE_SCALE = 3'd5
  } mode_e;

  typedef struct packed {
    logic                     bad;
    logic                     polar;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic [31:0] t;
    unique case (i)
      0:  t = 32'h3243F6A8;
      1:  t = 32'h1DAC6705;
      2:  t = 32'h0FADBAFC;
      3:  t = 32'h07F56EA6;
      4:  t = 32'h03FEAB76;
      5:  t = 32'h01FFD55B;
      6:  t = 32'h00FFFAAA;
      7:  t = 32'h007FFF55;
      8:  t = 32'h003FFFEA;
      9:  t = 32'h001FFFFD;
      10: t = 32'h000FFFFF;
      11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF;
      13: t = 32'h0001FFFF;
      14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF;
      16: t = 32'h00003FFF;
      17: t = 32'h00001FFF;
      18: t = 32'h00000FFF;
      19: t = 32'h000007FF;
      20: t = 32'h000003FF;
      21: t = 32'h000001FF;
      22: t = 32'h000000FF;
      23: t = 32'h0000007F;
      24: t = 32'h0000003F;
      25: t = 32'h0000001F;
      26: t = 32'h0000000F;
      27: t = 32'h00000008;
      28: t = 32'h00000004;
      29: t = 32'h00000002;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return $signed({2'b00, t});
  endfunction

endpackage

// ===== src/vrp_in_if.sv =====
interface vrp_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        mode;
  logic signed [vrp_pkg::CoordW-1:0] first_value;
  logic signed [vrp_pkg::CoordW-1:0] second_value;
  logic signed [vrp_pkg::CoordW-1:0] other_x;
  logic signed [vrp_pkg::CoordW-1:0] other_y;
  logic signed [vrp_pkg::CoordW-1:0] scale_factor;

  modport source (output valid, mode, first_value, second_value, other_x, other_y,
                  scale_factor, input ready);
  modport sink (input valid, mode, first_value, second_value, other_x, other_y,
                scale_factor, output ready);
endinterface

// ===== src/vrp_out_if.sv =====
interface vrp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vrp_pkg::CoordW-1:0] x_out;
  logic signed [vrp_pkg::CoordW-1:0] y_out;
  logic [vrp_pkg::CoordW-1:0]        magnitude_out;
  logic signed [vrp_pkg::AngW-1:0]   angle_out;
  logic                              bad_mode;

  modport source (output valid, x_out, y_out, magnitude_out, angle_out, bad_mode,
                  input ready);
  modport sink (input valid, x_out, y_out, magnitude_out, angle_out, bad_mode,
                output ready);
endinterface

// ===== src/vrp_rot.sv =====
module vrp_rot (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  vrp_pkg::side_t                    side_i,
  input  logic signed [vrp_pkg::CoordW-1:0] mag_i,
  input  logic signed [vrp_pkg::CoordW-1:0] deg_i,
  output logic                              valid_o,
  output vrp_pkg::side_t                    side_o
);
  import vrp_pkg::*;

  // Degrees in Q16.16: one full turn and half of it.
  localparam logic signed [27:0] FullT    = 28'sd23592960;
  localparam logic signed [27:0] HalfT    = 28'sd11796480;
  localparam logic signed [27:0] NegHalfT = -28'sd11796480;
  localparam logic signed [27:0] OneHalfT = 28'sd35389440;
  localparam logic signed [35:0] FullT36  = 36'sd23592960;
  // floor(2^40 / full turn), used to estimate the turn count.
  localparam logic signed [17:0] TurnRecip = 18'sd46603;
  localparam logic [31:0]        DegToRad  = 32'd74961321;
  localparam logic [31:0]        HalfPiU   = 32'd1686629713;

  function automatic logic signed [CoordW-1:0] rnd_sat(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0]        s;
    logic signed [CordW-GuardW-1:0] t;
    s = v + CordW'(1 << (GuardW - 1));
    t = s[CordW-1:GuardW];
    if (&t[CordW-GuardW-1:CoordW-1] || ~|t[CordW-GuardW-1:CoordW-1]) begin
      return t[CoordW-1:0];
    end
    return t[CordW-GuardW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
  endfunction

  logic                     v1_q, v2_q, v3_q, v4_q;
  side_t                    s1_q, s2_q, s3_q, s4_q;
  logic signed [49:0]       qprod;
  logic [62:0]              gprod;
  logic signed [9:0]        q1_q;
  logic signed [CoordW-1:0] deg1_q;
  logic [39:0]              g1_q;
  logic                     gneg1_q;
  logic signed [35:0]       r0w;
  logic signed [27:0]       r0_q;
  logic signed [CordW-1:0]  xg2_q, xg3_q, xg4_q;
  logic signed [27:0]       r3w;
  logic signed [24:0]       r3_q;
  logic [23:0]              ar;
  logic [55:0]              zprod;
  logic [31:0]              z4_q;
  logic                     zneg4_q;
  logic [CoordW-1:0]        mag_abs;

  logic                     cv_q [Stages+1];
  side_t                    cs_q [Stages+1];
  logic signed [CordW-1:0]  cx_q [Stages+1];
  logic signed [CordW-1:0]  cy_q [Stages+1];
  logic signed [ZW-1:0]     cz_q [Stages+1];

  logic                     zbig;
  logic signed [ZW-1:0]     zz, z5;

  assign qprod   = deg_i * TurnRecip;
  assign mag_abs = mag_i[CoordW-1] ? CoordW'(-mag_i) : mag_i;
  assign gprod   = mag_abs * GainInv;

  always_comb begin
    r0w = 36'(deg1_q) - 36'(q1_q) * FullT36;
  end

  always_comb begin
    priority if (r0_q < NegHalfT) begin
      r3w = r0_q + FullT;
    end else if (r0_q < HalfT) begin
      r3w = r0_q;
    end else if (r0_q < OneHalfT) begin
      r3w = r0_q - FullT;
    end else begin
      r3w = r0_q - FullT - FullT;
    end
  end

  assign ar    = r3_q[24] ? 24'(-r3_q) : 24'(r3_q);
  assign zprod = ar * DegToRad;

  // Fold angles beyond a quarter turn by a fixed quarter rotation first.
  assign zbig = z4_q > HalfPiU;
  assign zz   = $signed({2'b00, z4_q});
  always_comb begin
    if (zbig) begin
      z5 = zneg4_q ? (HalfPiQ30 - zz) : (zz - HalfPiQ30);
    end else begin
      z5 = zneg4_q ? -zz : zz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      cv_q[0]  <= 1'b0;
      valid_o  <= 1'b0;
    end else if (en_i) begin
      v1_q     <= valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      cv_q[0]  <= v4_q;
      valid_o  <= cv_q[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q    <= side_i;
      q1_q    <= qprod[49:40];
      deg1_q  <= deg_i;
      g1_q    <= gprod[62:23];
      gneg1_q <= mag_i[CoordW-1];

      s2_q    <= s1_q;
      r0_q    <= r0w[27:0];
      xg2_q   <= gneg1_q ? -CordW'(g1_q) : CordW'(g1_q);

      s3_q    <= s2_q;
      r3_q    <= r3w[24:0];
      xg3_q   <= xg2_q;

      s4_q    <= s3_q;
      z4_q    <= zprod[49:18];
      zneg4_q <= r3_q[24];
      xg4_q   <= xg3_q;

      cs_q[0] <= s4_q;
      cz_q[0] <= z5;
      if (zbig) begin
        cx_q[0] <= '0;
        cy_q[0] <= zneg4_q ? -xg4_q : xg4_q;
      end else begin
        cx_q[0] <= xg4_q;
        cy_q[0] <= '0;
      end

      side_o <= cs_q[Stages];
      if (cs_q[Stages].polar) begin
        side_o.x <= rnd_sat(cx_q[Stages]);
        side_o.y <= rnd_sat(cy_q[Stages]);
      end
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic signed [CordW-1:0] dx, dy;
    logic signed [ZW-1:0]    at;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    assign at = atan_q30(i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (en_i) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cs_q[i+1] <= cs_q[i];
        if (!cz_q[i][ZW-1]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - at;
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + at;
        end
      end
    end
  end

endmodule

// ===== src/vrp_vec.sv =====
module vrp_vec (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  vrp_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic signed [vrp_pkg::CoordW-1:0] x_o,
  output logic signed [vrp_pkg::CoordW-1:0] y_o,
  output logic [vrp_pkg::CoordW-1:0]        mag_o,
  output logic signed [vrp_pkg::AngW-1:0]   ang_o,
  output logic                              bad_o
);
  import vrp_pkg::*;

  localparam logic signed [ZW-1:0] AngRnd = ZW'(1 << (29 - FracW));
  localparam logic [43:0]          MagRnd = 44'(1 << (GuardW - 1));

  logic signed [CordW-1:0] xe, ye;
  logic                    zero_in;

  logic                    cv_q [Stages+1];
  side_t                   cs_q [Stages+1];
  logic                    ck_q [Stages+1];
  logic signed [CordW-1:0] cx_q [Stages+1];
  logic signed [CordW-1:0] cy_q [Stages+1];
  logic signed [ZW-1:0]    cz_q [Stages+1];

  logic                    v1_q, v2_q;
  side_t                   s1_q, s2_q;
  logic                    k1_q, k2_q;
  logic signed [ZW-1:0]    zc, za;
  logic [42:0]             xp;
  logic [49:0]             ph, ph1_q;
  logic [54:0]             ql, ql1_q;
  logic signed [AngW-1:0]  ang1_q, ang2_q;
  logic [55:0]             lowsum;
  logic [43:0]             t2_q, tr;

  assign xe = $signed({{(CordW-CoordW-GuardW){side_i.x[CoordW-1]}}, side_i.x,
                       {GuardW{1'b0}}});
  assign ye = $signed({{(CordW-CoordW-GuardW){side_i.y[CoordW-1]}}, side_i.y,
                       {GuardW{1'b0}}});
  assign zero_in = (side_i.x == '0) && (side_i.y == '0);

  // Angle clamp to the half turn, then round to Q2.16.
  always_comb begin
    priority if (cz_q[Stages] > PiQ30) begin
      zc = PiQ30;
    end else if (cz_q[Stages] < -PiQ30) begin
      zc = -PiQ30;
    end else begin
      zc = cz_q[Stages];
    end
    za = zc + AngRnd;
  end

  // The gain product is split so that each multiplier stays narrow.
  assign xp     = cx_q[Stages][CordW-1] ? '0 : cx_q[Stages][42:0];
  assign ph     = xp[42:24] * GainInv;
  assign ql     = xp[23:0] * GainInv;
  assign lowsum = 56'({ph1_q[6:0], 24'b0}) + 56'(ql1_q);
  assign tr     = t2_q + MagRnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      cv_q[0] <= valid_i;
      v1_q    <= cv_q[Stages];
      v2_q    <= v1_q;
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_q[0] <= side_i;
      ck_q[0] <= zero_in || side_i.bad;
      if (side_i.x[CoordW-1]) begin
        if (!side_i.y[CoordW-1]) begin
          cx_q[0] <= ye;
          cy_q[0] <= -xe;
          cz_q[0] <= HalfPiQ30;
        end else begin
          cx_q[0] <= -ye;
          cy_q[0] <= xe;
          cz_q[0] <= -HalfPiQ30;
        end
      end else begin
        cx_q[0] <= xe;
        cy_q[0] <= ye;
        cz_q[0] <= '0;
      end

      s1_q   <= cs_q[Stages];
      k1_q   <= ck_q[Stages];
      ang1_q <= za[ZW-2:ZW-1-AngW];
      ph1_q  <= ph;
      ql1_q  <= ql;

      s2_q   <= s1_q;
      k2_q   <= k1_q;
      ang2_q <= ang1_q;
      t2_q   <= 44'(ph1_q[49:7]) + 44'(lowsum[55:31]);

      x_o   <= s2_q.x;
      y_o   <= s2_q.y;
      bad_o <= s2_q.bad;
      if (k2_q) begin
        mag_o <= '0;
        ang_o <= '0;
      end else begin
        mag_o <= (|tr[43:CoordW+GuardW]) ? '1 : tr[CoordW+GuardW-1:GuardW];
        ang_o <= ang2_q;
      end
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic signed [CordW-1:0] dx, dy;
    logic signed [ZW-1:0]    at;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    assign at = atan_q30(i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (en_i) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cs_q[i+1] <= cs_q[i];
        ck_q[i+1] <= ck_q[i];
        if (!cy_q[i][CordW-1]) begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + at;
        end else begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - at;
        end
      end
    end
  end

endmodule

// ===== src/vector_rect_polar_unit_core.sv =====
// Channel   Port    Direction  Carries
// input     src_i   sink       mode, first_value, second_value, other_x, other_y,
//                              scale_factor
// result    res_o   source     x_out, y_out, magnitude_out, angle_out, bad_mode
//
// One item is taken every cycle while no result waits; each result passes
// through the two 16-stage CORDIC pipelines plus the scaling, degree-reduction
// and gain stages around them.
// Reset clears only the valid bits of the stages.
// When a result waits, every stage holds together, so nothing is dropped or
// repeated; the input is ready whenever the output register is empty or taken.
module vector_rect_polar_unit_core (
  input logic      clk_i,
  input logic      rst_ni,
  vrp_in_if.sink   src_i,
  vrp_out_if.source res_o
);
  import vrp_pkg::*;

  function automatic logic signed [CoordW-1:0] sat_c(input logic signed [CoordW:0] v);
    if (v[CoordW] != v[CoordW-1]) begin
      return v[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
    return v[CoordW-1:0];
  endfunction

  logic                      adv;
  logic                      v0_q, v1_q, v2_q;
  mode_e                     mode0_q, mode1_q;
  logic signed [CoordW-1:0]  a0_q, b0_q, ox0_q, oy0_q, n0_q;
  logic signed [CoordW-1:0]  a1_q, b1_q, a2_q, b2_q;
  logic signed [CoordW:0]    ax, bx, oxx, oyx, opx, opy;
  logic signed [CoordW-1:0]  alux1_q, aluy1_q;
  logic [CoordW-1:0]         na, aa, ba;
  logic [2*CoordW-1:0]       pa1_q, pb1_q;
  logic                      nega1_q, negb1_q;
  logic signed [CoordW-1:0]  scx, scy;
  side_t                     sd, s2_q, rot_side;
  logic                      rot_v, vec_v;
  logic signed [CoordW-1:0]  vx, vy;
  logic [CoordW-1:0]         vmag;
  logic signed [AngW-1:0]    vang;
  logic                      vbad;

  function automatic logic signed [CoordW-1:0] scale_sat(input logic [2*CoordW-1:0] p,
                                                         input logic neg);
    logic [2*CoordW-FracW-1:0] r;
    r = p[2*CoordW-1:FracW];
    if (!neg) begin
      return (|r[2*CoordW-FracW-1:CoordW-1]) ? {1'b0, {(CoordW-1){1'b1}}} : r[CoordW-1:0];
    end
    if (r > (2*CoordW-FracW)'({1'b1, {(CoordW-1){1'b0}}})) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end
    return -r[CoordW-1:0];
  endfunction

  assign adv         = !vec_v || res_o.ready;
  assign src_i.ready = adv;

  assign ax  = {a0_q[CoordW-1], a0_q};
  assign bx  = {b0_q[CoordW-1], b0_q};
  assign oxx = {ox0_q[CoordW-1], ox0_q};
  assign oyx = {oy0_q[CoordW-1], oy0_q};

  always_comb begin
    unique case (mode0_q)
      MODE_ADD: begin
        opx = ax + oxx;
        opy = bx + oyx;
      end
      MODE_SUB: begin
        opx = ax - oxx;
        opy = bx - oyx;
      end
      MODE_NEG: begin
        opx = -ax;
        opy = -bx;
      end
      default: begin
        opx = ax;
        opy = bx;
      end
    endcase
  end

  assign na = n0_q[CoordW-1] ? CoordW'(-n0_q) : n0_q;
  assign aa = a0_q[CoordW-1] ? CoordW'(-a0_q) : a0_q;
  assign ba = b0_q[CoordW-1] ? CoordW'(-b0_q) : b0_q;

  assign scx = scale_sat(pa1_q, nega1_q);
  assign scy = scale_sat(pb1_q, negb1_q);

  always_comb begin
    sd       = '0;
    sd.polar = (mode1_q == MODE_POLAR);
    unique case (mode1_q)
      MODE_RECT, MODE_ADD, MODE_SUB, MODE_NEG: begin
        sd.x = alux1_q;
        sd.y = aluy1_q;
      end
      MODE_SCALE: begin
        sd.x = scx;
        sd.y = scy;
      end
      MODE_POLAR: begin
        sd.x = '0;
        sd.y = '0;
      end
      default: begin
        sd.bad = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v0_q <= src_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode0_q <= mode_e'(src_i.mode);
      a0_q    <= src_i.first_value;
      b0_q    <= src_i.second_value;
      ox0_q   <= src_i.other_x;
      oy0_q   <= src_i.other_y;
      n0_q    <= src_i.scale_factor;

      mode1_q <= mode0_q;
      a1_q    <= a0_q;
      b1_q    <= b0_q;
      alux1_q <= sat_c(opx);
      aluy1_q <= sat_c(opy);
      pa1_q   <= na * aa;
      pb1_q   <= na * ba;
      nega1_q <= n0_q[CoordW-1] ^ a0_q[CoordW-1];
      negb1_q <= n0_q[CoordW-1] ^ b0_q[CoordW-1];

      s2_q <= sd;
      a2_q <= a1_q;
      b2_q <= b1_q;
    end
  end

  vrp_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .side_i  (s2_q),
    .mag_i   (a2_q),
    .deg_i   (b2_q),
    .valid_o (rot_v),
    .side_o  (rot_side)
  );

  vrp_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (rot_v),
    .side_i  (rot_side),
    .valid_o (vec_v),
    .x_o     (vx),
    .y_o     (vy),
    .mag_o   (vmag),
    .ang_o   (vang),
    .bad_o   (vbad)
  );

  assign res_o.valid         = vec_v;
  assign res_o.x_out         = vx;
  assign res_o.y_out         = vy;
  assign res_o.magnitude_out = vmag;
  assign res_o.angle_out     = vang;
  assign res_o.bad_mode      = vbad;

endmodule
